[rtl/pbh_pkg.sv]
`timescale 1ns / 1ps
// shared types and codes for the price level best heap
// no dependencies

package pbh_pkg;

  localparam logic [2:0] ST_CREATED   = 3'd0;
  localparam logic [2:0] ST_EXISTS    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  localparam logic ACT_CREATE = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_START,
    OP_SCAN,
    OP_SET_EXIST,
    OP_SET_FULL,
    OP_SET_NF,
    OP_CREATE,
    OP_REM0,
    OP_REM1,
    OP_REM2,
    OP_UP0,
    OP_UP1,
    OP_UP_MOVE,
    OP_SINK0,
    OP_SINK1,
    OP_SINK2,
    OP_SINK3,
    OP_DN_MOVE,
    OP_PLACE,
    OP_TOP0,
    OP_TOP1,
    OP_TOP2,
    OP_EMIT
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_REM1,
    S_REM2,
    S_UP0,
    S_UP1,
    S_UP2,
    S_SINK0,
    S_SINK1,
    S_SINK2,
    S_SINK3,
    S_SINK4,
    S_PLACE,
    S_TOP0,
    S_TOP1,
    S_TOP2,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic scan_last;
    logic hit;
    logic full;
    logic act;
    logic pos_lt;
    logic pos_zero;
    logic fl_sink;
    logic up_beat;
    logic leaf;
    logic r_exists;
    logic dn_beat;
    logic empty;
  } st_t;

endpackage

[rtl/pbh_dp.sv]
`timescale 1ns / 1ps
// datapath: price scan, heap and level memories, sift registers, result register
// depends on pbh_pkg

module pbh_dp #(
  parameter int MAX_LEVELS = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pbh_pkg::op_t     op,
  input  logic             high_best,
  input  logic             in_action,
  input  logic [31:0]      in_price,
  output pbh_pkg::st_t     st,
  output logic [2:0]       res_status,
  output logic [5:0]       res_handle,
  output logic             res_best_valid,
  output logic [31:0]      res_best_price,
  output logic [5:0]       res_best_handle,
  output logic [6:0]       res_count
);

  localparam int HW = $clog2(MAX_LEVELS);
  localparam int CW = $clog2(MAX_LEVELS + 1);
  localparam int LW = HW + 2;
  localparam int PW = PRICE_BITS;

  logic [HW-1:0] hs_mem  [MAX_LEVELS];
  logic [HW-1:0] pos_mem [MAX_LEVELS];
  logic [PW-1:0] pr_mem  [MAX_LEVELS];

  logic [HW-1:0] hs_q, pos_q;
  logic [PW-1:0] pr_q;

  logic [HW-1:0] hs_ra, pos_ra, pr_ra, hs_wa, hs_wd, pr_wa;
  logic          hs_we, pr_we;

  logic [MAX_LEVELS-1:0] in_use_r;
  logic [CW-1:0] cnt_r, idx_r;
  logic          act_r, hit_r, free_ok_r, fl_sink_r;
  logic [PW-1:0] pin_r, x_p_r, a_p_r;
  logic [HW-1:0] hit_h_r, free_h_r, pos_r, x_h_r, a_h_r, b_h_r, a_pos_r;
  logic [2:0]    rs_r;
  logic [HW-1:0] rh_r;

  logic [2:0]    o_status_r;
  logic [5:0]    o_handle_r, o_bh_r;
  logic          o_bv_r;
  logic [31:0]   o_bp_r;
  logic [6:0]    o_cnt_r;

  logic [HW-1:0] parent, scan_j;
  logic [LW-1:0] l_w, r_w, cnt_w;

  function automatic logic beats(input logic bid, input logic [PW-1:0] a,
                                 input logic [PW-1:0] b);
    beats = bid ? (a > b) : (a < b);
  endfunction

  assign parent = HW'((pos_r - HW'(1)) >> 1);
  assign scan_j = HW'(idx_r - CW'(1));
  assign l_w    = LW'({pos_r, 1'b1});
  assign r_w    = l_w + LW'(1);
  assign cnt_w  = LW'(cnt_r);

  always_comb begin
    hs_ra  = '0;
    pos_ra = hit_h_r;
    pr_ra  = hs_q;
    hs_we  = 1'b0;
    hs_wa  = pos_r;
    hs_wd  = a_h_r;
    pr_we  = 1'b0;
    pr_wa  = free_h_r;
    unique case (op)
      pbh_pkg::OP_SCAN:    pr_ra = idx_r[HW-1:0];
      pbh_pkg::OP_REM0:    hs_ra = HW'(cnt_r - CW'(1));
      pbh_pkg::OP_UP0:     hs_ra = parent;
      pbh_pkg::OP_SINK0:   hs_ra = l_w[HW-1:0];
      pbh_pkg::OP_SINK1:   hs_ra = r_w[HW-1:0];
      pbh_pkg::OP_CREATE:  pr_we = 1'b1;
      pbh_pkg::OP_UP_MOVE,
      pbh_pkg::OP_DN_MOVE: hs_we = 1'b1;
      pbh_pkg::OP_PLACE: begin
        hs_we = 1'b1;
        hs_wd = x_h_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hs_we) hs_mem[hs_wa] <= hs_wd;
    hs_q <= hs_mem[hs_ra];
  end

  always_ff @(posedge clk) begin
    if (hs_we) pos_mem[hs_wd] <= hs_wa;
    pos_q <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (pr_we) pr_mem[pr_wa] <= pin_r;
    pr_q <= pr_mem[pr_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      cnt_r    <= '0;
    end else begin
      unique case (op)
        pbh_pkg::OP_CREATE: begin
          in_use_r[free_h_r] <= 1'b1;
          cnt_r              <= cnt_r + CW'(1);
        end
        pbh_pkg::OP_REM0: begin
          in_use_r[hit_h_r] <= 1'b0;
          cnt_r             <= cnt_r - CW'(1);
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    unique case (op)
      pbh_pkg::OP_START: begin
        act_r     <= in_action;
        pin_r     <= PW'(in_price);
        idx_r     <= '0;
        hit_r     <= 1'b0;
        free_ok_r <= 1'b0;
      end
      pbh_pkg::OP_SCAN: begin
        idx_r <= idx_r + CW'(1);
        if (idx_r != '0) begin
          if (in_use_r[scan_j] && pr_q == pin_r) begin
            hit_r   <= 1'b1;
            hit_h_r <= scan_j;
          end
          if (!in_use_r[scan_j] && !free_ok_r) begin
            free_ok_r <= 1'b1;
            free_h_r  <= scan_j;
          end
        end
      end
      pbh_pkg::OP_SET_EXIST: begin
        rs_r <= pbh_pkg::ST_EXISTS;
        rh_r <= hit_h_r;
      end
      pbh_pkg::OP_SET_FULL: begin
        rs_r <= pbh_pkg::ST_FULL;
        rh_r <= '0;
      end
      pbh_pkg::OP_SET_NF: begin
        rs_r <= pbh_pkg::ST_NOT_FOUND;
        rh_r <= '0;
      end
      pbh_pkg::OP_CREATE: begin
        rs_r      <= pbh_pkg::ST_CREATED;
        rh_r      <= free_h_r;
        x_h_r     <= free_h_r;
        x_p_r     <= pin_r;
        pos_r     <= HW'(cnt_r);
        fl_sink_r <= 1'b0;
      end
      pbh_pkg::OP_REM0: begin
        rs_r      <= pbh_pkg::ST_REMOVED;
        rh_r      <= hit_h_r;
        fl_sink_r <= 1'b1;
      end
      pbh_pkg::OP_REM1: begin
        pos_r <= pos_q;
        x_h_r <= hs_q;
      end
      pbh_pkg::OP_REM2:  x_p_r <= pr_q;
      pbh_pkg::OP_UP1:   a_h_r <= hs_q;
      pbh_pkg::OP_UP_MOVE: begin
        pos_r     <= parent;
        fl_sink_r <= 1'b0;
      end
      pbh_pkg::OP_SINK1: a_h_r <= hs_q;
      pbh_pkg::OP_SINK2: begin
        a_p_r   <= pr_q;
        b_h_r   <= hs_q;
        a_pos_r <= l_w[HW-1:0];
      end
      pbh_pkg::OP_SINK3: begin
        if (beats(high_best, pr_q, a_p_r)) begin
          a_h_r   <= b_h_r;
          a_p_r   <= pr_q;
          a_pos_r <= r_w[HW-1:0];
        end
      end
      pbh_pkg::OP_DN_MOVE: pos_r <= a_pos_r;
      pbh_pkg::OP_TOP1:  a_h_r <= hs_q;
      pbh_pkg::OP_TOP2:  a_p_r <= pr_q;
      pbh_pkg::OP_EMIT: begin
        o_status_r <= rs_r;
        o_handle_r <= 6'(rh_r);
        o_bv_r     <= (cnt_r != '0);
        o_bp_r     <= (cnt_r != '0) ? 32'(a_p_r) : '0;
        o_bh_r     <= (cnt_r != '0) ? 6'(a_h_r) : '0;
        o_cnt_r    <= 7'(cnt_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    st.scan_last = (idx_r == CW'(MAX_LEVELS));
    st.hit       = hit_r;
    st.full      = (cnt_r == CW'(MAX_LEVELS));
    st.act       = act_r;
    st.pos_lt    = (CW'(pos_r) < cnt_r);
    st.pos_zero  = (pos_r == '0);
    st.fl_sink   = fl_sink_r;
    st.up_beat   = beats(high_best, x_p_r, pr_q);
    st.leaf      = (l_w >= cnt_w);
    st.r_exists  = (r_w < cnt_w);
    st.dn_beat   = beats(high_best, a_p_r, x_p_r);
    st.empty     = (cnt_r == '0);
  end

  assign res_status      = o_status_r;
  assign res_handle      = o_handle_r;
  assign res_best_valid  = o_bv_r;
  assign res_best_price  = o_bp_r;
  assign res_best_handle = o_bh_r;
  assign res_count       = o_cnt_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_LEVELS))
    else $error("level count above capacity");

  a_create_free: assert property (@(posedge clk) disable iff (!rst_n)
    op == pbh_pkg::OP_CREATE |-> free_ok_r && !in_use_r[free_h_r])
    else $error("create without a free handle");

  a_remove_clears: assert property (@(posedge clk) disable iff (!rst_n)
    op == pbh_pkg::OP_REM0 |=> !in_use_r[$past(hit_h_r)])
    else $error("removed level still in use");

endmodule

[rtl/pbh_ctrl.sv]
`timescale 1ns / 1ps
// controller: sequences scan, insert, remove, sift and result transfer
// depends on pbh_pkg

module pbh_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  pbh_pkg::st_t     st,
  output pbh_pkg::op_t     op
);

  pbh_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pbh_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = pbh_pkg::OP_IDLE;
    emit      = 1'b0;
    unique case (state_r)
      pbh_pkg::S_IDLE: begin
        if (in_valid) begin
          op        = pbh_pkg::OP_START;
          state_nxt = pbh_pkg::S_SCAN;
        end
      end
      pbh_pkg::S_SCAN: begin
        op = pbh_pkg::OP_SCAN;
        if (st.scan_last) state_nxt = pbh_pkg::S_DECIDE;
      end
      pbh_pkg::S_DECIDE: begin
        priority if (st.act == pbh_pkg::ACT_CREATE && st.hit) begin
          op        = pbh_pkg::OP_SET_EXIST;
          state_nxt = pbh_pkg::S_TOP0;
        end else if (st.act == pbh_pkg::ACT_CREATE && st.full) begin
          op        = pbh_pkg::OP_SET_FULL;
          state_nxt = pbh_pkg::S_TOP0;
        end else if (st.act == pbh_pkg::ACT_CREATE) begin
          op        = pbh_pkg::OP_CREATE;
          state_nxt = pbh_pkg::S_UP0;
        end else if (!st.hit) begin
          op        = pbh_pkg::OP_SET_NF;
          state_nxt = pbh_pkg::S_TOP0;
        end else begin
          op        = pbh_pkg::OP_REM0;
          state_nxt = pbh_pkg::S_REM1;
        end
      end
      pbh_pkg::S_REM1: begin
        op        = pbh_pkg::OP_REM1;
        state_nxt = pbh_pkg::S_REM2;
      end
      pbh_pkg::S_REM2: begin
        op        = pbh_pkg::OP_REM2;
        state_nxt = st.pos_lt ? pbh_pkg::S_UP0 : pbh_pkg::S_TOP0;
      end
      pbh_pkg::S_UP0: begin
        op = pbh_pkg::OP_UP0;
        if (!st.pos_zero) state_nxt = pbh_pkg::S_UP1;
        else state_nxt = st.fl_sink ? pbh_pkg::S_SINK0 : pbh_pkg::S_PLACE;
      end
      pbh_pkg::S_UP1: begin
        op        = pbh_pkg::OP_UP1;
        state_nxt = pbh_pkg::S_UP2;
      end
      pbh_pkg::S_UP2: begin
        if (st.up_beat) begin
          op        = pbh_pkg::OP_UP_MOVE;
          state_nxt = pbh_pkg::S_UP0;
        end else begin
          state_nxt = st.fl_sink ? pbh_pkg::S_SINK0 : pbh_pkg::S_PLACE;
        end
      end
      pbh_pkg::S_SINK0: begin
        op        = pbh_pkg::OP_SINK0;
        state_nxt = st.leaf ? pbh_pkg::S_PLACE : pbh_pkg::S_SINK1;
      end
      pbh_pkg::S_SINK1: begin
        op        = pbh_pkg::OP_SINK1;
        state_nxt = pbh_pkg::S_SINK2;
      end
      pbh_pkg::S_SINK2: begin
        op        = pbh_pkg::OP_SINK2;
        state_nxt = st.r_exists ? pbh_pkg::S_SINK3 : pbh_pkg::S_SINK4;
      end
      pbh_pkg::S_SINK3: begin
        op        = pbh_pkg::OP_SINK3;
        state_nxt = pbh_pkg::S_SINK4;
      end
      pbh_pkg::S_SINK4: begin
        if (st.dn_beat) begin
          op        = pbh_pkg::OP_DN_MOVE;
          state_nxt = pbh_pkg::S_SINK0;
        end else begin
          state_nxt = pbh_pkg::S_PLACE;
        end
      end
      pbh_pkg::S_PLACE: begin
        op        = pbh_pkg::OP_PLACE;
        state_nxt = pbh_pkg::S_TOP0;
      end
      pbh_pkg::S_TOP0: begin
        op        = pbh_pkg::OP_TOP0;
        state_nxt = st.empty ? pbh_pkg::S_EMIT : pbh_pkg::S_TOP1;
      end
      pbh_pkg::S_TOP1: begin
        op        = pbh_pkg::OP_TOP1;
        state_nxt = pbh_pkg::S_TOP2;
      end
      pbh_pkg::S_TOP2: begin
        op        = pbh_pkg::OP_TOP2;
        state_nxt = pbh_pkg::S_EMIT;
      end
      pbh_pkg::S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          op        = pbh_pkg::OP_EMIT;
          emit      = 1'b1;
          state_nxt = pbh_pkg::S_IDLE;
        end
      end
      default: state_nxt = pbh_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    priority if (emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign in_ready  = (state_r == pbh_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pbh_pkg::S_EMIT && out_valid_r && !out_ready |=> state_r == pbh_pkg::S_EMIT)
    else $error("result overwritten while stalled");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    op == pbh_pkg::OP_EMIT |=> out_valid_r && in_ready)
    else $error("result not presented after emit");

endmodule

[rtl/price_level_best_heap_unit.sv]
`timescale 1ns / 1ps
// top level: configuration register, controller and datapath of one book side
// depends on pbh_pkg, pbh_ctrl, pbh_dp
//
// Input transaction: in_action (0 create or find, 1 remove) and in_price on a
// valid/ready channel. One result transaction per input on the out_ channel:
// status, handle, best level (valid, price, handle) and level count.
// One item is handled at a time. Every item first scans the level price
// memory, one entry per cycle, and then decides. An insert then rises
// while it beats its parent; a remove moves the last entry into the freed
// slot, unless the freed slot was the last, and it rises or sinks there.
// The moved entry is then placed, and the top of the heap is read.
// The result sits in an output register; the next item is taken while it
// waits, and that item holds in its last step until the register is free.
// Reset empties the side and selects highest price as best; no memory
// clearing pass is needed. The side select (address 0) is written over the
// APB-style cfg_ port; write it only while the block is idle: the block
// itself does not enforce it.

module price_level_best_heap_unit #(
  parameter int MAX_LEVELS = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [31:0] in_price,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [5:0]  out_level_handle,
  output logic        out_best_valid,
  output logic [31:0] out_best_price,
  output logic [5:0]  out_best_handle,
  output logic [6:0]  out_level_count
);

  logic high_best_r, high_best_nxt;
  logic cfg_wr;
  pbh_pkg::op_t op;
  pbh_pkg::st_t st;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    high_best_nxt = high_best_r;
    if (cfg_wr && cfg_paddr[2] == 1'b0) high_best_nxt = cfg_pwdata[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) high_best_r <= 1'b1;
    else high_best_r <= high_best_nxt;
  end

  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {31'd0, high_best_r} : '0;

  pbh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .op        (op)
  );

  pbh_dp #(
    .MAX_LEVELS (MAX_LEVELS),
    .PRICE_BITS (PRICE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .op              (op),
    .high_best       (high_best_r),
    .in_action       (in_action),
    .in_price        (in_price),
    .st              (st),
    .res_status      (out_status),
    .res_handle      (out_level_handle),
    .res_best_valid  (out_best_valid),
    .res_best_price  (out_best_price),
    .res_best_handle (out_best_handle),
    .res_count       (out_level_count)
  );

endmodule
